// ===== src/mme_pkg.sv =====
`timescale 1ns / 1ps
// mme_pkg: shared types and constants of the matrix multiply engine.
// Depends on nothing; imported by every module of the block but mme_ram.
package mme_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int DIM_W       = 4;
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_IDX_W   = 3;

  localparam logic [1:0] ACT_LOAD_A = 2'd0;
  localparam logic [1:0] ACT_LOAD_B = 2'd1;
  localparam logic [1:0] ACT_START  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_C_ROWS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_C_COLS = 3'd5;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd4;

  typedef struct packed {
    logic [1:0]                action;
    logic [POS_W-1:0]          row_index;
    logic [POS_W-1:0]          col_index;
    logic signed [VALUE_W-1:0] elem_value;
  } mme_in_t;

  typedef struct packed {
    logic [POS_W-1:0]          out_row;
    logic [POS_W-1:0]          out_col;
    logic signed [VALUE_W-1:0] product_value;
    logic                      dims_ok;
    logic                      last_elem;
  } mme_out_t;

  typedef enum logic [1:0] {
    KIND_LOAD_A,
    KIND_LOAD_B,
    KIND_RUN
  } mme_kind_t;

  // queued command: a load carries row/col/value, a run carries the dims
  typedef struct packed {
    mme_kind_t          kind;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [VALUE_W-1:0] value;
    logic [DIM_W-1:0]   c_rows;
    logic [DIM_W-1:0]   c_cols;
    logic [DIM_W-1:0]   inner;
    logic               ok;
  } mme_cmd_t;

  // tag that travels down the multiply-accumulate pipeline
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             last_elem;
    logic             ok;
    logic             zero;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } mme_tag_t;

endpackage

// ===== src/mme_ram.sv =====
`timescale 1ns / 1ps
// mme_ram: generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
module mme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/mme_queue.sv =====
`timescale 1ns / 1ps
// mme_queue: short command queue between front and back.
// Depends on mme_pkg.
module mme_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mme_pkg::mme_cmd_t push_data,
  input  logic            pop,
  output mme_pkg::mme_cmd_t head,
  output logic            empty,
  output logic            full
);
  import mme_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  mme_cmd_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;

  assign empty = (count == '0);
  assign full  = (count == (PTR_W + 1)'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/mme_front.sv =====
`timescale 1ns / 1ps
// mme_front: dimension registers, item intake and classification into commands.
// Depends on mme_pkg.
module mme_front #(
  parameter int MAX_DIM = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  mme_pkg::mme_in_t              item,
  input  logic                          q_full,
  output logic                          busy,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mme_pkg::DIM_W-1:0]     cfg_data,
  output logic                          push,
  output mme_pkg::mme_cmd_t             cmd
);
  import mme_pkg::*;

  logic [DIM_W-1:0] a_rows, a_cols, b_rows, b_cols, c_rows, c_cols;
  logic [DIM_W-1:0] e_ar, e_ac, e_br, e_bc, e_cr, e_cc;
  logic             in_range;
  logic             keep;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    return (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
  endfunction

  assign cfg_ready = 1'b1;
  assign busy      = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows <= DIM_RESET;
      a_cols <= DIM_RESET;
      b_rows <= DIM_RESET;
      b_cols <= DIM_RESET;
      c_rows <= DIM_RESET;
      c_cols <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_A_ROWS: a_rows <= cfg_data;
        REG_A_COLS: a_cols <= cfg_data;
        REG_B_ROWS: b_rows <= cfg_data;
        REG_B_COLS: b_cols <= cfg_data;
        REG_C_ROWS: c_rows <= cfg_data;
        REG_C_COLS: c_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  assign e_ar = eff_dim(a_rows);
  assign e_ac = eff_dim(a_cols);
  assign e_br = eff_dim(b_rows);
  assign e_bc = eff_dim(b_cols);
  assign e_cr = eff_dim(c_rows);
  assign e_cc = eff_dim(c_cols);

  assign in_range = (int'(item.row_index) < MAX_DIM) && (int'(item.col_index) < MAX_DIM);

  always_comb begin
    cmd        = '0;
    cmd.row    = item.row_index;
    cmd.col    = item.col_index;
    cmd.value  = item.elem_value;
    cmd.c_rows = e_cr;
    cmd.c_cols = e_cc;
    cmd.inner  = e_br;
    cmd.ok     = (e_ac == e_br) && (e_cr == e_ar) && (e_cc == e_bc);
    keep       = 1'b0;
    unique case (item.action)
      ACT_LOAD_A: begin
        cmd.kind = KIND_LOAD_A;
        keep     = in_range;
      end
      ACT_LOAD_B: begin
        cmd.kind = KIND_LOAD_B;
        keep     = in_range;
      end
      ACT_START: begin
        cmd.kind = KIND_RUN;
        keep     = 1'b1;
      end
      default: begin
        cmd.kind = KIND_RUN;
        keep     = 1'b0;
      end
    endcase
  end

  assign push = start && !busy && keep;

endmodule

// ===== src/mme_back.sv =====
`timescale 1ns / 1ps
// mme_back: executes queued commands: element stores and the MAC pipeline.
// Depends on mme_pkg and mme_ram.
module mme_back #(
  parameter int MAX_DIM    = 8,
  parameter int VALUE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  mme_pkg::mme_cmd_t head,
  input  logic              empty,
  output logic              pop,
  output mme_pkg::mme_out_t result,
  output logic              result_valid
);
  import mme_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int PW    = 2 * VALUE_BITS;
  localparam int ACC_W = PW + 4;
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W - VALUE_BITS + 1){1'b0}}, {(VALUE_BITS - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO =
    {{(ACC_W - VALUE_BITS + 1){1'b1}}, {(VALUE_BITS - 1){1'b0}}};

  typedef enum logic {IDLE, RUN} state_t;

  state_t             state;
  logic [IW-1:0]      m, p, n;
  logic [DIM_W-1:0]   cr, cc, steps;
  logic               job_ok, job_zero;
  logic               last_n, last_p, last_m;

  logic               we_a, we_b;
  logic [AW-1:0]      waddr, ra_addr, rb_addr;
  logic signed [VALUE_BITS-1:0] a_q, b_q;

  mme_tag_t                  s1, s2, s3;
  logic signed [PW-1:0]      prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [VALUE_BITS-1:0] sat_v;

  logic               run_ok;

  assign pop   = (state == IDLE) && !empty;
  assign we_a  = pop && (head.kind == KIND_LOAD_A);
  assign we_b  = pop && (head.kind == KIND_LOAD_B);
  assign waddr = AW'(int'(head.row) * MAX_DIM + int'(head.col));

  assign ra_addr = AW'(int'(m) * MAX_DIM + int'(n));
  assign rb_addr = AW'(int'(n) * MAX_DIM + int'(p));

  assign last_n = (DIM_W'(n) == steps - 1'b1);
  assign last_p = (DIM_W'(p) == cc - 1'b1);
  assign last_m = (DIM_W'(m) == cr - 1'b1);
  assign run_ok = head.ok && (head.inner != '0);

  mme_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_a_ram (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (head.value[VALUE_BITS-1:0]),
    .raddr (ra_addr),
    .rdata (a_q)
  );

  mme_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_b_ram (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (head.value[VALUE_BITS-1:0]),
    .raddr (rb_addr),
    .rdata (b_q)
  );

  // sequencer: one inner-product step issued per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m        <= '0;
      p        <= '0;
      n        <= '0;
      cr       <= '0;
      cc       <= '0;
      steps    <= '0;
      job_ok   <= 1'b0;
      job_zero <= 1'b0;
      s1       <= '0;
    end else begin
      s1.valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (pop && head.kind == KIND_RUN) begin
            m        <= '0;
            p        <= '0;
            n        <= '0;
            cr       <= head.c_rows;
            cc       <= head.c_cols;
            steps    <= run_ok ? head.inner : DIM_W'(1);
            job_ok   <= head.ok;
            job_zero <= !run_ok;
            if (head.c_rows != '0 && head.c_cols != '0) begin
              state <= RUN;
            end
          end
        end
        RUN: begin
          s1.valid     <= 1'b1;
          s1.first     <= (n == '0);
          s1.last      <= last_n;
          s1.last_elem <= last_n && last_p && last_m;
          s1.ok        <= job_ok;
          s1.zero      <= job_zero;
          s1.row       <= POS_W'(m);
          s1.col       <= POS_W'(p);
          if (!last_n) begin
            n <= n + 1'b1;
          end else begin
            n <= '0;
            if (!last_p) begin
              p <= p + 1'b1;
            end else begin
              p <= '0;
              if (!last_m) begin
                m <= m + 1'b1;
              end else begin
                state <= IDLE;
              end
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s1.zero) begin
      prod <= '0;
    end else begin
      prod <= a_q * b_q;
    end
    if (s2.valid) begin
      if (s2.first) begin
        acc <= ACC_W'(prod >>> FRAC_BITS);
      end else begin
        acc <= acc + ACC_W'(prod >>> FRAC_BITS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2 <= '0;
      s3 <= '0;
    end else begin
      s2 <= s1;
      s3 <= s2;
    end
  end

  always_comb begin
    if (acc > SAT_HI) begin
      sat_v = SAT_HI[VALUE_BITS-1:0];
    end else if (acc < SAT_LO) begin
      sat_v = SAT_LO[VALUE_BITS-1:0];
    end else begin
      sat_v = acc[VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= s3.valid && s3.last;
    end
  end

  always_ff @(posedge clk) begin
    if (s3.valid && s3.last) begin
      result.out_row       <= s3.row;
      result.out_col       <= s3.col;
      result.product_value <= VALUE_W'(sat_v);
      result.dims_ok       <= s3.ok;
      result.last_elem     <= s3.last_elem;
    end
  end

endmodule

// ===== src/matrix_multiply_engine.sv =====
`timescale 1ns / 1ps
// Matrix multiply engine, C = A * B in signed Q16.16 with saturation.
// Each load is one back-end store; a start accumulates K products for each of the cr*cc
// results, K = inner dim (1 on mismatch or empty inner dim), on the single MAC, one read per RAM.
// Each step passes the RAM read, product, accumulator and result registers in turn.
// busy rises only when the four-entry command queue is full; the receiver cannot stall.
// Synchronous reset clears queue, sequencer and dims (all 4); element stores are not cleared.
module matrix_multiply_engine #(
  parameter int MAX_DIM    = 8,
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  mme_pkg::mme_in_t              item,
  output logic                          busy,
  output mme_pkg::mme_out_t             result,
  output logic                          result_valid,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mme_pkg::DIM_W-1:0]     cfg_data
);
  import mme_pkg::*;

  mme_cmd_t cmd, head;
  logic     push, pop, empty, full;

  mme_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .q_full    (full),
    .busy      (busy),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .cmd       (cmd)
  );

  mme_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cmd),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  mme_back #(.MAX_DIM(MAX_DIM), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

// ===== bench/matrix_multiply_engine_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for matrix_multiply_engine: loads, runs and dimension writes.
// Depends on mme_pkg and the engine RTL only.
module matrix_multiply_engine_test;
  import mme_pkg::*;

  localparam int         MAX_DIM    = 8;
  localparam int         ITEM_GOAL  = 470;
  localparam int         SETTLE     = 64;
  localparam int         QUIET_MAX  = 2000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam longint     SAT_HI     = 64'sd2147483647;
  localparam longint     SAT_LO     = -SAT_HI - 1;

  typedef struct {
    bit                   is_cfg;
    mme_in_t              word;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;
  } cmd_entry_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  mme_in_t              item = '0;
  logic                 busy;
  mme_out_t             result;
  logic                 result_valid;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;

  matrix_multiply_engine dut (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy),
    .result(result), .result_valid(result_valid),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cmd_entry_t command_fifo[$];
  mme_out_t   pending_products[$];
  int         mismatch_count = 0;
  int         issued_items = 0;

  // shadow of the engine as seen through accepted words
  logic signed [VALUE_W-1:0] a_mem [MAX_DIM][MAX_DIM];
  logic signed [VALUE_W-1:0] b_mem [MAX_DIM][MAX_DIM];
  logic [DIM_W-1:0]          dims_now [6];

  // generator side: dims it has planned and entries it has loaded
  logic [DIM_W-1:0] plan_dims [6];
  bit               a_loaded [MAX_DIM][MAX_DIM];
  bit               b_loaded [MAX_DIM][MAX_DIM];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned eff_dim(logic [DIM_W-1:0] r);
    return (r > MAX_DIM) ? MAX_DIM : r;
  endfunction

  task automatic compute_product_run();
    int unsigned ar, ac, br, bc, cr, cc;
    bit          ok;
    longint      acc, prod;
    mme_out_t    r;
    ar = eff_dim(dims_now[REG_A_ROWS]);
    ac = eff_dim(dims_now[REG_A_COLS]);
    br = eff_dim(dims_now[REG_B_ROWS]);
    bc = eff_dim(dims_now[REG_B_COLS]);
    cr = eff_dim(dims_now[REG_C_ROWS]);
    cc = eff_dim(dims_now[REG_C_COLS]);
    ok = (ac == br) && (cr == ar) && (cc == bc);
    for (int m = 0; m < cr; m++) begin
      for (int p = 0; p < cc; p++) begin
        acc = 0;
        if (ok) begin
          for (int n = 0; n < br; n++) begin
            prod = longint'(a_mem[m][n]) * longint'(b_mem[n][p]);
            acc += prod >>> FRAC_BITS;
          end
          if (acc > SAT_HI) acc = SAT_HI;
          else if (acc < SAT_LO) acc = SAT_LO;
        end
        r.out_row       = m[POS_W-1:0];
        r.out_col       = p[POS_W-1:0];
        r.product_value = acc[VALUE_W-1:0];
        r.dims_ok       = ok;
        r.last_elem     = (m == cr - 1) && (p == cc - 1);
        pending_products.push_back(r);
      end
    end
  endtask

  task automatic apply_word(mme_in_t w);
    case (w.action)
      ACT_LOAD_A: a_mem[w.row_index][w.col_index] = w.elem_value;
      ACT_LOAD_B: b_mem[w.row_index][w.col_index] = w.elem_value;
      ACT_START:  compute_product_run();
      default: ;
    endcase
  endtask

  // driver: presents queued words, draws a gap after each, tracks the shadow state
  int gap_left, burst_left;
  bit idle_on;

  always @(posedge clk) begin : drive
    logic       go_start, go_cfg;
    cmd_entry_t nxt;
    go_start = start;
    go_cfg   = cfg_valid;
    if (rst) begin
      go_start   = 1'b0;
      go_cfg     = 1'b0;
      gap_left   = 0;
      burst_left = 0;
      idle_on    = 1'b0;
      for (int i = 0; i < 6; i++) dims_now[i] = DIM_RESET;
    end else begin
      if (start && !busy) begin
        apply_word(item);
        go_start = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        dims_now[cfg_index] = cfg_data;
        go_cfg = 1'b0;
      end
      if (!go_start && !go_cfg) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (command_fifo.size() > 0) begin
          nxt = command_fifo.pop_front();
          if (nxt.is_cfg) begin
            go_cfg = 1'b1;
            cfg_index <= nxt.index;
            cfg_data <= nxt.data;
          end else begin
            go_start = 1'b1;
            item <= nxt.word;
          end
          if (burst_left == 0) begin
            burst_left = $urandom_range(4, 30);
            idle_on    = 1'($urandom_range(0, 1));
          end
          burst_left--;
          gap_left = idle_on ? $urandom_range(0, 17) : 0;
        end
      end
    end
    start <= go_start;
    cfg_valid <= go_cfg;
  end

  // monitor: every strobed word against the oldest expected product
  always @(posedge clk) begin : check
    mme_out_t want;
    if (!rst && result_valid) begin
      if (pending_products.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: row %0d col %0d value %h ok %b last %b",
                   result.out_row, result.out_col, result.product_value,
                   result.dims_ok, result.last_elem);
      end else begin
        want = pending_products.pop_front();
        if (result.out_row !== want.out_row || result.out_col !== want.out_col ||
            result.product_value !== want.product_value ||
            result.dims_ok !== want.dims_ok || result.last_elem !== want.last_elem) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: exp row %0d col %0d value %h ok %b last %b, got %s",
                     want.out_row, want.out_col, want.product_value, want.dims_ok,
                     want.last_elem,
                     $sformatf("row %0d col %0d value %h ok %b last %b",
                               result.out_row, result.out_col, result.product_value,
                               result.dims_ok, result.last_elem));
        end
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || result_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---- stimulus ----

  task automatic wait_quiet();
    do @(negedge clk);
    while (command_fifo.size() != 0 || start || cfg_valid || pending_products.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push_word(mme_in_t w);
    cmd_entry_t e;
    e.is_cfg = 1'b0;
    e.word   = w;
    e.index  = '0;
    e.data   = '0;
    command_fifo.push_back(e);
    if (w.action != ACT_UNUSED) issued_items++;
  endtask

  task automatic set_dims(logic [DIM_W-1:0] d0, logic [DIM_W-1:0] d1, logic [DIM_W-1:0] d2,
                          logic [DIM_W-1:0] d3, logic [DIM_W-1:0] d4, logic [DIM_W-1:0] d5);
    cmd_entry_t e;
    wait_quiet();
    plan_dims[REG_A_ROWS] = d0;
    plan_dims[REG_A_COLS] = d1;
    plan_dims[REG_B_ROWS] = d2;
    plan_dims[REG_B_COLS] = d3;
    plan_dims[REG_C_ROWS] = d4;
    plan_dims[REG_C_COLS] = d5;
    e.is_cfg = 1'b1;
    e.word   = '0;
    for (int i = 0; i < 6; i++) begin
      e.index = i[CFG_IDX_W-1:0];
      e.data  = plan_dims[i];
      command_fifo.push_back(e);
    end
  endtask

  function automatic logic [VALUE_W-1:0] draw_value();
    logic [VALUE_W-1:0] corners [7] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                                        32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000,
                                        32'hFFFF_0000};
    case ($urandom_range(0, 7))
      0:       return corners[$urandom_range(0, 6)];
      1, 2:    return $urandom;
      default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  task automatic push_load(logic [1:0] act, int row, int col, logic [VALUE_W-1:0] v);
    mme_in_t w;
    w.action     = act;
    w.row_index  = row[POS_W-1:0];
    w.col_index  = col[POS_W-1:0];
    w.elem_value = v;
    if (act == ACT_LOAD_A) a_loaded[row][col] = 1'b1;
    else b_loaded[row][col] = 1'b1;
    push_word(w);
  endtask

  // a run with matching dims first loads whatever it would read that was never loaded
  task automatic push_start();
    int unsigned ar, ac, br, bc;
    mme_in_t     w;
    ar = eff_dim(plan_dims[REG_A_ROWS]);
    ac = eff_dim(plan_dims[REG_A_COLS]);
    br = eff_dim(plan_dims[REG_B_ROWS]);
    bc = eff_dim(plan_dims[REG_B_COLS]);
    if (ac == br && eff_dim(plan_dims[REG_C_ROWS]) == ar &&
        eff_dim(plan_dims[REG_C_COLS]) == bc) begin
      for (int m = 0; m < ar; m++)
        for (int n = 0; n < ac; n++)
          if (!a_loaded[m][n]) push_load(ACT_LOAD_A, m, n, draw_value());
      for (int n = 0; n < br; n++)
        for (int p = 0; p < bc; p++)
          if (!b_loaded[n][p]) push_load(ACT_LOAD_B, n, p, draw_value());
    end
    w.action     = ACT_START;
    w.row_index  = POS_W'($urandom);
    w.col_index  = POS_W'($urandom);
    w.elem_value = $urandom;
    push_word(w);
  endtask

  task automatic push_noise();
    mme_in_t w;
    w.action     = ACT_UNUSED;
    w.row_index  = POS_W'($urandom);
    w.col_index  = POS_W'($urandom);
    w.elem_value = $urandom;
    push_word(w);
  endtask

  task automatic push_random_load();
    logic [1:0]  act;
    int unsigned rows, cols, row, col;
    act  = $urandom_range(0, 1) ? ACT_LOAD_B : ACT_LOAD_A;
    rows = eff_dim(plan_dims[act == ACT_LOAD_A ? REG_A_ROWS : REG_B_ROWS]);
    cols = eff_dim(plan_dims[act == ACT_LOAD_A ? REG_A_COLS : REG_B_COLS]);
    if (rows > 0 && cols > 0 && $urandom_range(0, 3) != 0) begin
      row = $urandom_range(0, rows - 1);
      col = $urandom_range(0, cols - 1);
    end else begin
      row = $urandom_range(0, MAX_DIM - 1);
      col = $urandom_range(0, MAX_DIM - 1);
    end
    push_load(act, row, col, draw_value());
  endtask

  function automatic logic [DIM_W-1:0] pick_extent();
    int unsigned r;
    r = $urandom_range(0, 11);
    if (r == 0) return '0;
    if (r <= 6) return DIM_W'($urandom_range(1, 3));
    if (r <= 9) return DIM_W'($urandom_range(4, 7));
    return DIM_W'($urandom_range(8, 15));
  endfunction

  task automatic set_random_dims();
    logic [DIM_W-1:0] d [6];
    logic [DIM_W-1:0] old;
    int               j;
    d[REG_A_ROWS] = pick_extent();
    d[REG_A_COLS] = pick_extent();
    d[REG_B_ROWS] = d[REG_A_COLS];
    d[REG_B_COLS] = pick_extent();
    d[REG_C_ROWS] = d[REG_A_ROWS];
    d[REG_C_COLS] = d[REG_B_COLS];
    if ($urandom_range(0, 3) == 0) begin
      j   = $urandom_range(0, 5);
      old = d[j];
      do d[j] = DIM_W'($urandom_range(0, 15));
      while (eff_dim(d[j]) == eff_dim(old));
    end
    set_dims(d[0], d[1], d[2], d[3], d[4], d[5]);
  endtask

  initial begin
    int budget, sel;
    bit first_phase;
    for (int i = 0; i < 6; i++) plan_dims[i] = DIM_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // 2x2 runs into both saturation limits, and floor on negative products
    set_dims(2, 2, 2, 2, 2, 2);
    push_load(ACT_LOAD_A, 0, 0, 32'h7FFF_FFFF);
    push_load(ACT_LOAD_A, 0, 1, 32'h7FFF_FFFF);
    push_load(ACT_LOAD_A, 1, 0, 32'h8000_0000);
    push_load(ACT_LOAD_A, 1, 1, 32'hFFFF_FFFF);
    push_load(ACT_LOAD_B, 0, 0, 32'h7FFF_FFFF);
    push_load(ACT_LOAD_B, 1, 0, 32'h7FFF_FFFF);
    push_load(ACT_LOAD_B, 0, 1, 32'h0000_0001);
    push_load(ACT_LOAD_B, 1, 1, 32'h0001_0000);
    push_noise();
    push_start();
    push_start();
    // inner dims disagree
    set_dims(2, 3, 2, 2, 2, 2);
    push_start();
    // everything zero: empty result
    set_dims(0, 0, 0, 0, 0, 0);
    push_start();
    // empty inner dimension still yields a 2x2 of zeros with dims matched
    set_dims(2, 0, 0, 2, 2, 2);
    push_start();
    // 1x1: 1.5 * -1.5
    set_dims(1, 1, 1, 1, 1, 1);
    push_load(ACT_LOAD_A, 0, 0, 32'h0001_8000);
    push_load(ACT_LOAD_B, 0, 0, 32'hFFFE_8000);
    push_start();

    first_phase = 1'b1;
    while (issued_items < ITEM_GOAL) begin
      if (first_phase) set_dims(15, 15, 15, 15, 15, 15);
      else set_random_dims();
      first_phase = 1'b0;
      budget = $urandom_range(15, 45);
      repeat (budget) begin
        sel = $urandom_range(0, 19);
        if (sel < 14) push_random_load();
        else if (sel < 15) push_noise();
        else push_start();
      end
      push_start();
    end

    wait_quiet();
    if (mismatch_count == 0 && pending_products.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
